/* rtl/wvn_pkg.sv */
package wvn_pkg;

   localparam int MAXCH    = 8;
   localparam int WEIGHT_W = 17;
   localparam int VERTEX_W = 20;
   localparam int KEPT_W   = 3;
   localparam int SUM_W    = 20;                // eight 17-bit weights
   localparam int QUO_W    = WEIGHT_W;          // rescaled weight never exceeds 1.0
   localparam int PROD_W   = 2 * WEIGHT_W + 1;  // w * num + den / 2
   localparam int REM_W    = SUM_W;
   localparam int QUEUE_DEPTH = 2;

   typedef logic [WEIGHT_W-1:0] weight_type;
   typedef weight_type [MAXCH-1:0] weight_vec_type;
   typedef logic [VERTEX_W-1:0] vertex_type;
   typedef logic [SUM_W-1:0] sum_type;

   localparam weight_type ONE_Q16 = weight_type'(65536);

   typedef enum logic [1:0] {
      OUTCOME_ZERO    = 2'd0,
      OUTCOME_KEEP    = 2'd1,
      OUTCOME_RESCALE = 2'd2
   } outcome_type;

   // one classified item on its way from the front to the back
   typedef struct packed {
      vertex_type          vertex;
      weight_vec_type      weights;
      outcome_type         outcome;
      logic [KEPT_W-1:0]   kept;
      logic                has_kept;
      logic                drop;
      weight_type          w0_alt;   // new transparency for keep and rescale
      weight_type          num;
      sum_type             den;
   } job_type;

endpackage

/* rtl/wvn_req_if.sv */
interface wvn_req_if;
   logic                 valid;
   logic                 ready;
   wvn_pkg::vertex_type  vertex_index;
   wvn_pkg::weight_type  weight_0;
   wvn_pkg::weight_type  weight_1;
   wvn_pkg::weight_type  weight_2;
   wvn_pkg::weight_type  weight_3;
   wvn_pkg::weight_type  weight_4;
   wvn_pkg::weight_type  weight_5;
   wvn_pkg::weight_type  weight_6;
   wvn_pkg::weight_type  weight_7;
   logic [2:0]           kept_channel;
   wvn_pkg::weight_type  upscale_floor;
   logic                 drop_transparency;

   modport source (output valid, vertex_index, weight_0, weight_1, weight_2, weight_3,
                   weight_4, weight_5, weight_6, weight_7, kept_channel, upscale_floor,
                   drop_transparency, input ready);
   modport sink   (input valid, vertex_index, weight_0, weight_1, weight_2, weight_3,
                   weight_4, weight_5, weight_6, weight_7, kept_channel, upscale_floor,
                   drop_transparency, output ready);
endinterface

/* rtl/wvn_rsp_if.sv */
interface wvn_rsp_if;
   logic                 valid;
   logic                 ready;
   wvn_pkg::vertex_type  vertex_out;
   wvn_pkg::weight_type  out_weight_0;
   wvn_pkg::weight_type  out_weight_1;
   wvn_pkg::weight_type  out_weight_2;
   wvn_pkg::weight_type  out_weight_3;
   wvn_pkg::weight_type  out_weight_4;
   wvn_pkg::weight_type  out_weight_5;
   wvn_pkg::weight_type  out_weight_6;
   wvn_pkg::weight_type  out_weight_7;
   logic [1:0]           outcome;

   modport source (output valid, vertex_out, out_weight_0, out_weight_1, out_weight_2,
                   out_weight_3, out_weight_4, out_weight_5, out_weight_6, out_weight_7,
                   outcome, input ready);
   modport sink   (input valid, vertex_out, out_weight_0, out_weight_1, out_weight_2,
                   out_weight_3, out_weight_4, out_weight_5, out_weight_6, out_weight_7,
                   outcome, output ready);
endinterface

/* rtl/wvn_front.sv */
module wvn_front #(
   parameter int CHANNELS        = 8,
   parameter int CLOSE_TOLERANCE = 1
) (
   input  logic              clock,
   input  logic              reset,
   wvn_req_if.sink           req_bus,
   output logic              job_valid,
   output wvn_pkg::job_type  job,
   input  logic              job_ready
);
   import wvn_pkg::*;

   logic              f_valid_ff, f_valid_in;
   vertex_type        vertex_ff;
   weight_vec_type    w_ff, w_in, w_raw;
   logic [KEPT_W-1:0] kept_ff;
   logic              has_kept_ff, has_kept_in;
   weight_type        floor_ff;
   logic              drop_ff;
   sum_type           sum_ff, sum_in;
   weight_type        keptw_ff, keptw_in;
   logic              advance;

   sum_type           diff;
   weight_type        sum_cl, floor_cl, target;

   assign advance       = !f_valid_ff || job_ready;
   assign req_bus.ready = advance;
   assign f_valid_in    = advance ? req_bus.valid : f_valid_ff;

   assign w_raw = {req_bus.weight_7, req_bus.weight_6, req_bus.weight_5, req_bus.weight_4,
                   req_bus.weight_3, req_bus.weight_2, req_bus.weight_1, req_bus.weight_0};

   always_comb begin
      for (int i = 0; i < MAXCH; i++) begin
         w_in[i] = (i < CHANNELS) ? w_raw[i] : '0;
      end
      has_kept_in = (req_bus.kept_channel != '0) && (int'(req_bus.kept_channel) < CHANNELS);
      keptw_in    = has_kept_in ? w_in[req_bus.kept_channel] : '0;
      sum_in      = '0;
      for (int i = 0; i < MAXCH; i++) begin
         if (i != 0 || !req_bus.drop_transparency) begin
            sum_in = sum_in + SUM_W'(w_in[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vertex_ff   <= req_bus.vertex_index;
         w_ff        <= w_in;
         kept_ff     <= req_bus.kept_channel;
         has_kept_ff <= has_kept_in;
         floor_ff    <= req_bus.upscale_floor;
         drop_ff     <= req_bus.drop_transparency;
         sum_ff      <= sum_in;
         keptw_ff    <= keptw_in;
      end
   end

   // classify; the kept weight is part of the sum, so sum >= kept weight
   always_comb begin
      diff     = sum_ff - SUM_W'(keptw_ff);
      sum_cl   = (sum_ff >= SUM_W'(ONE_Q16)) ? ONE_Q16 : WEIGHT_W'(sum_ff);
      floor_cl = (floor_ff > ONE_Q16) ? ONE_Q16 : floor_ff;
      target   = (floor_cl > sum_cl) ? floor_cl : sum_cl;

      job.vertex   = vertex_ff;
      job.weights  = w_ff;
      job.kept     = kept_ff;
      job.has_kept = has_kept_ff;
      job.drop     = drop_ff;
      job.num      = (target > keptw_ff) ? target - keptw_ff : '0;
      job.den      = diff;
      if (sum_ff == '0) begin
         job.outcome = OUTCOME_ZERO;
         job.w0_alt  = w_ff[0];
      end else if (diff <= SUM_W'(CLOSE_TOLERANCE)) begin
         job.outcome = OUTCOME_KEEP;
         if (drop_ff) begin
            job.w0_alt = (keptw_ff >= ONE_Q16) ? '0 : ONE_Q16 - keptw_ff;
         end else begin
            job.w0_alt = '0;
         end
      end else begin
         job.outcome = OUTCOME_RESCALE;
         job.w0_alt  = ONE_Q16 - target;
      end
   end

   assign job_valid = f_valid_ff;

endmodule

/* rtl/wvn_fifo.sv */
module wvn_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  wvn_pkg::job_type  push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output wvn_pkg::job_type  pop_data
);
   import wvn_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   job_type              mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]       count_ff, count_in;
   logic                 push, pop;

   assign push_ready = (count_ff != (PTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ((wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1)
                       : wr_ptr_ff;
      rd_ptr_in = pop  ? ((rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1)
                       : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/wvn_back.sv */
module wvn_back #(
   parameter int CHANNELS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  wvn_pkg::job_type  job_in,
   wvn_rsp_if.source         rsp_bus
);
   import wvn_pkg::*;

   // stage 0: multiply, stages 1..QUO_W: one quotient bit each, LAST: result
   localparam int LAST = QUO_W + 1;

   logic            valid_ff [LAST+1];
   job_type         job_ff   [LAST];
   logic            en;
   logic [QUO_W-1:0] quo_fin [MAXCH];

   vertex_type      vertex_out_ff;
   weight_vec_type  out_w_ff, out_w_in;
   outcome_type     outcome_ff;

   assign en        = !valid_ff[LAST] || rsp_bus.ready;
   assign job_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= LAST; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= job_valid;
         for (int s = 1; s <= LAST; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         job_ff[0] <= job_in;
         for (int s = 1; s < LAST; s++) begin
            job_ff[s] <= job_ff[s-1];
         end
      end
   end

   for (genvar c = 0; c < MAXCH; c++) begin : g_ch
      if (c >= 1 && c < CHANNELS) begin : g_div
         logic [REM_W-1:0]  rem_ff [QUO_W+1];
         logic [REM_W-1:0]  rem_in [QUO_W+1];
         logic [QUO_W-1:0]  low_ff [QUO_W+1];
         logic [QUO_W-1:0]  low_in [QUO_W+1];
         logic [QUO_W-1:0]  quo_ff [QUO_W+1];
         logic [QUO_W-1:0]  quo_in [QUO_W+1];
         logic [PROD_W-1:0] prod;
         logic [REM_W:0]    r2, dn;

         // round to nearest: (w * num + den / 2) / den, quotient fits QUO_W bits
         always_comb begin
            prod = PROD_W'(job_in.weights[c]) * PROD_W'(job_in.num)
                 + PROD_W'(job_in.den[SUM_W-1:1]);
            rem_in[0] = REM_W'(prod[PROD_W-1:QUO_W]);
            low_in[0] = prod[QUO_W-1:0];
            quo_in[0] = '0;
            r2 = '0;
            dn = '0;
            for (int d = 1; d <= QUO_W; d++) begin
               r2 = {rem_ff[d-1], low_ff[d-1][QUO_W-d]};
               dn = {1'b0, job_ff[d-1].den};
               if (r2 >= dn) begin
                  rem_in[d] = REM_W'(r2 - dn);
                  quo_in[d] = {quo_ff[d-1][QUO_W-2:0], 1'b1};
               end else begin
                  rem_in[d] = REM_W'(r2);
                  quo_in[d] = {quo_ff[d-1][QUO_W-2:0], 1'b0};
               end
               low_in[d] = low_ff[d-1];
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               for (int d = 0; d <= QUO_W; d++) begin
                  rem_ff[d] <= rem_in[d];
                  low_ff[d] <= low_in[d];
                  quo_ff[d] <= quo_in[d];
               end
            end
         end

         assign quo_fin[c] = quo_ff[QUO_W];
      end else begin : g_none
         assign quo_fin[c] = '0;
      end
   end

   always_comb begin
      for (int c = 0; c < MAXCH; c++) begin
         case (job_ff[QUO_W].outcome)
            OUTCOME_ZERO: begin
               out_w_in[c] = job_ff[QUO_W].weights[c];
            end
            OUTCOME_KEEP: begin
               if (job_ff[QUO_W].has_kept && job_ff[QUO_W].kept == KEPT_W'(c)) begin
                  out_w_in[c] = job_ff[QUO_W].drop ? job_ff[QUO_W].weights[c] : ONE_Q16;
               end else if (c == 0) begin
                  out_w_in[c] = job_ff[QUO_W].w0_alt;
               end else begin
                  out_w_in[c] = '0;
               end
            end
            OUTCOME_RESCALE: begin
               if (c == 0) begin
                  out_w_in[c] = job_ff[QUO_W].w0_alt;
               end else if (job_ff[QUO_W].has_kept && job_ff[QUO_W].kept == KEPT_W'(c)) begin
                  out_w_in[c] = job_ff[QUO_W].weights[c];
               end else begin
                  out_w_in[c] = quo_fin[c];
               end
            end
            default: begin
               out_w_in[c] = job_ff[QUO_W].weights[c];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vertex_out_ff <= job_ff[QUO_W].vertex;
         out_w_ff      <= out_w_in;
         outcome_ff    <= job_ff[QUO_W].outcome;
      end
   end

   assign rsp_bus.valid        = valid_ff[LAST];
   assign rsp_bus.vertex_out   = vertex_out_ff;
   assign rsp_bus.out_weight_0 = out_w_ff[0];
   assign rsp_bus.out_weight_1 = out_w_ff[1];
   assign rsp_bus.out_weight_2 = out_w_ff[2];
   assign rsp_bus.out_weight_3 = out_w_ff[3];
   assign rsp_bus.out_weight_4 = out_w_ff[4];
   assign rsp_bus.out_weight_5 = out_w_ff[5];
   assign rsp_bus.out_weight_6 = out_w_ff[6];
   assign rsp_bus.out_weight_7 = out_w_ff[7];
   assign rsp_bus.outcome      = outcome_ff;

endmodule

/* rtl/weight_vector_normalizer.sv */
// channel   dir  ports        payload
// request   in   req_bus.*    vertex_index, weight_0..7, kept_channel, upscale_floor,
//                             drop_transparency
// response  out  rsp_bus.*    vertex_out, out_weight_0..7, outcome
//
// One item per cycle sustained while the response is not stalled. An item passes
// through one front register, one queue slot, one multiply stage, 17 quotient-bit
// stages of the rescale divider and the result register. Reset is synchronous and
// clears all valid state. A stalled response freezes the back pipeline; the
// two-entry queue and the front register keep taking items until they fill.
module weight_vector_normalizer #(
   parameter int CHANNELS        = 8,
   parameter int CLOSE_TOLERANCE = 1
) (
   input  logic       clock,
   input  logic       reset,
   wvn_req_if.sink    req_bus,
   wvn_rsp_if.source  rsp_bus
);
   import wvn_pkg::*;

   logic     push_valid, push_ready, pop_valid, pop_ready;
   job_type  push_data, pop_data;

   wvn_front #(
      .CHANNELS        (CHANNELS),
      .CLOSE_TOLERANCE (CLOSE_TOLERANCE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .job_valid (push_valid),
      .job       (push_data),
      .job_ready (push_ready)
   );

   wvn_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   wvn_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job_ready (pop_ready),
      .job_in    (pop_data),
      .rsp_bus   (rsp_bus)
   );

endmodule

/* rtl/wvn_checker.sv */
module wvn_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [1:0]           rsp_outcome,
   input wvn_pkg::weight_type  w0,
   input wvn_pkg::weight_type  w1,
   input wvn_pkg::weight_type  w2,
   input wvn_pkg::weight_type  w3,
   input wvn_pkg::weight_type  w4,
   input wvn_pkg::weight_type  w5,
   input wvn_pkg::weight_type  w6,
   input wvn_pkg::weight_type  w7
);
   import wvn_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_outcome) && $stable(w0))
      else $error("stalled response changed");

   a_rescale_w0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == OUTCOME_RESCALE |-> w0 <= ONE_Q16)
      else $error("rescaled transparency above one");

   a_keep_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == OUTCOME_KEEP |->
         $countones({w1 != '0, w2 != '0, w3 != '0, w4 != '0,
                     w5 != '0, w6 != '0, w7 != '0}) <= 1)
      else $error("keep result with more than one influence set");

endmodule

bind weight_vector_normalizer wvn_checker u_wvn_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_outcome (rsp_bus.outcome),
   .w0          (rsp_bus.out_weight_0),
   .w1          (rsp_bus.out_weight_1),
   .w2          (rsp_bus.out_weight_2),
   .w3          (rsp_bus.out_weight_3),
   .w4          (rsp_bus.out_weight_4),
   .w5          (rsp_bus.out_weight_5),
   .w6          (rsp_bus.out_weight_6),
   .w7          (rsp_bus.out_weight_7)
);
